FILE: hdl/tesq_pkg.sv
// ----------------------------------------------------------------------------
// tesq_pkg
// Shared constants, codes and types of the timed event scheduler queue.
// ----------------------------------------------------------------------------
package tesq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_EVENTS  = 64;

	localparam int OPW  = 3;
	localparam int IDW  = 7;
	localparam int TW   = 64;
	localparam int STW  = 2;
	localparam int QIW  = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int EIW  = $clog2(MAX_EVENTS);

	localparam logic [OPW-1:0] OP_ALLOC  = 3'd0;
	localparam logic [OPW-1:0] OP_SCHED  = 3'd1;
	localparam logic [OPW-1:0] OP_CANCEL = 3'd2;
	localparam logic [OPW-1:0] OP_QUERY  = 3'd3;
	localparam logic [OPW-1:0] OP_FREE   = 3'd4;

	localparam logic [STW-1:0] ST_OK       = 2'd0;
	localparam logic [STW-1:0] ST_NOT_ALLOC = 2'd1;
	localparam logic [STW-1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [STW-1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [IDW-1:0] event_id;
		logic [TW-1:0]  due;
	} slot_t;

endpackage

FILE: hdl/tesq_if.sv
// ----------------------------------------------------------------------------
// tesq_in_if / tesq_out_if
// Valid/ready channels for commands and results of the scheduler queue.
// ----------------------------------------------------------------------------
interface tesq_in_if import tesq_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [OPW-1:0] op;
	logic [IDW-1:0] event_id;
	logic [TW-1:0]  target_tick;
	logic [TW-1:0]  now_tick;

	modport source (output valid, op, event_id, target_tick, now_tick, input ready);
	modport sink (input valid, op, event_id, target_tick, now_tick, output ready);
endinterface

interface tesq_out_if import tesq_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [STW-1:0] status;
	logic [IDW-1:0] new_id;
	logic           was_queued;
	logic [TW-1:0]  entry_tick;
	logic           was_clamped;

	modport source (output valid, status, new_id, was_queued, entry_tick, was_clamped,
		input ready);
	modport sink (input valid, status, new_id, was_queued, entry_tick, was_clamped,
		output ready);
endinterface

FILE: hdl/timed_event_scheduler_queue_top.sv
// ----------------------------------------------------------------------------
// timed_event_scheduler_queue_top
// Sorted timer event queue with an identifier allocation table.
// ----------------------------------------------------------------------------
// Entries live in one slot RAM kept sorted by due tick; a sequencer scans,
// shifts and inserts one slot at a time, reading and then checking or
// writing each slot, as every RAM read is registered. Allocate, unknown
// commands and commands on unallocated identifiers go straight to the result;
// the others scan for the entry, cancel, free and a moved reschedule shift
// later entries down, and a reschedule inserts. One command is in work at a
// time; a result waits in an output register while a new command is taken.
module timed_event_scheduler_queue_top import tesq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tesq_in_if.sink   cmd,
	tesq_out_if.source rsp
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_FIND_RD   = 4'd1;
	localparam logic [3:0] S_FIND_CK   = 4'd2;
	localparam logic [3:0] S_DECIDE    = 4'd3;
	localparam logic [3:0] S_REM_RD    = 4'd4;
	localparam logic [3:0] S_REM_WR    = 4'd5;
	localparam logic [3:0] S_INS_BEGIN = 4'd6;
	localparam logic [3:0] S_INS_RD    = 4'd7;
	localparam logic [3:0] S_INS_CK    = 4'd8;
	localparam logic [3:0] S_INS_W0    = 4'd9;
	localparam logic [3:0] S_RESP      = 4'd10;

	logic [3:0]            state_q;
	logic [OPW-1:0]        op_q;
	logic [IDW-1:0]        id_q;
	logic [TW-1:0]         tick_q;
	logic [TW-1:0]         due_q;
	logic [CNTW-1:0]       cnt_q;
	logic [QIW-1:0]        idx_q;
	logic [QIW-1:0]        pos_q;
	logic                  found_q;
	logic [MAX_EVENTS-1:0] alloc_q;
	logic [IDW-1:0]        last_q;

	logic [STW-1:0] res_status_q;
	logic [IDW-1:0] res_new_id_q;
	logic           res_queued_q;
	logic [TW-1:0]  res_etick_q;
	logic           res_clamped_q;

	logic           rsp_valid_q;
	logic [STW-1:0] rsp_status_q;
	logic [IDW-1:0] rsp_new_id_q;
	logic           rsp_queued_q;
	logic [TW-1:0]  rsp_etick_q;
	logic           rsp_clamped_q;

	logic           ram_we;
	logic [QIW-1:0] ram_waddr;
	logic [QIW-1:0] ram_raddr;
	slot_t          ram_wdata;
	slot_t          ram_rdata;

	logic           in_clamp;
	logic [TW-1:0]  in_tick;
	logic           in_id_ok;
	logic [IDW-1:0] cand;
	logic [EIW-1:0] cand_idx;
	logic [EIW-1:0] in_idx;
	logic [EIW-1:0] id_idx;
	logic [3:0]     rm_next;
	logic           alloc_ok;
	logic [STW-1:0] in_status;
	logic [3:0]     in_next;
	logic           rsp_load;

	tesq_ram #(.WIDTH($bits(slot_t)), .DEPTH(QUEUE_DEPTH)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.new_id      = rsp_new_id_q;
	assign rsp.was_queued  = rsp_queued_q;
	assign rsp.entry_tick  = rsp_etick_q;
	assign rsp.was_clamped = rsp_clamped_q;

	assign in_clamp = cmd.target_tick < cmd.now_tick;
	assign in_tick  = in_clamp ? cmd.now_tick : cmd.target_tick;
	assign in_idx   = EIW'(cmd.event_id - IDW'(1));
	assign in_id_ok = (cmd.event_id != '0) && (cmd.event_id <= IDW'(MAX_EVENTS))
		&& alloc_q[in_idx];
	assign cand     = (last_q >= IDW'(MAX_EVENTS)) ? IDW'(1) : last_q + IDW'(1);
	assign cand_idx = EIW'(cand - IDW'(1));
	assign id_idx   = EIW'(id_q - IDW'(1));
	assign rm_next  = (op_q == OP_SCHED) ? S_INS_BEGIN : S_RESP;
	assign alloc_ok = !alloc_q[cand_idx];
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		in_status = ST_OK;
		in_next   = S_RESP;
		case (cmd.op)
			OP_ALLOC: begin
				if (!alloc_ok) begin
					in_status = ST_EXHAUSTED;
				end
			end
			OP_SCHED, OP_CANCEL, OP_QUERY, OP_FREE: begin
				if (!in_id_ok) begin
					in_status = ST_NOT_ALLOC;
				end else begin
					in_next = (cnt_q == '0) ? S_DECIDE : S_FIND_RD;
				end
			end
			default: begin
				in_next = S_RESP;
			end
		endcase
	end

	always_comb begin
		ram_raddr = idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		case (state_q)
			S_REM_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q - QIW'(1);
			end
			S_INS_CK: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q + QIW'(1);
				if (ram_rdata.due <= tick_q) begin
					ram_wdata = '{event_id: id_q, due: tick_q};
				end
			end
			S_INS_W0: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = '{event_id: id_q, due: tick_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			alloc_q     <= '0;
			last_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q          <= cmd.op;
						id_q          <= cmd.event_id;
						tick_q        <= in_tick;
						idx_q         <= '0;
						found_q       <= 1'b0;
						res_status_q  <= in_status;
						res_new_id_q  <= (cmd.op == OP_ALLOC && alloc_ok) ? cand : '0;
						res_queued_q  <= 1'b0;
						res_etick_q   <= '0;
						res_clamped_q <= (cmd.op == OP_SCHED) && in_id_ok && in_clamp;
						state_q       <= in_next;
						if (cmd.op == OP_ALLOC && alloc_ok) begin
							alloc_q[cand_idx] <= 1'b1;
							last_q            <= cand;
						end
					end
				end
				S_FIND_RD: begin
					state_q <= S_FIND_CK;
				end
				S_FIND_CK: begin
					if (ram_rdata.event_id == id_q) begin
						found_q <= 1'b1;
						pos_q   <= idx_q;
						due_q   <= ram_rdata.due;
						state_q <= S_DECIDE;
					end else if (CNTW'(idx_q) + CNTW'(1) == cnt_q) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q   <= idx_q + QIW'(1);
						state_q <= S_FIND_RD;
					end
				end
				S_DECIDE: begin
					res_queued_q <= found_q;
					if (found_q && (op_q == OP_SCHED || op_q == OP_QUERY)) begin
						res_etick_q <= due_q;
					end
					if (op_q == OP_FREE) begin
						alloc_q[id_idx] <= 1'b0;
					end
					if (op_q == OP_SCHED && !found_q) begin
						if (cnt_q == CNTW'(QUEUE_DEPTH)) begin
							res_status_q <= ST_FULL;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_INS_BEGIN;
						end
					end else if (found_q && (op_q == OP_CANCEL || op_q == OP_FREE
						|| (op_q == OP_SCHED && due_q != tick_q))) begin
						if (CNTW'(pos_q) + CNTW'(1) < cnt_q) begin
							idx_q   <= pos_q + QIW'(1);
							state_q <= S_REM_RD;
						end else begin
							cnt_q   <= cnt_q - CNTW'(1);
							state_q <= rm_next;
						end
					end else begin
						state_q <= S_RESP;
					end
				end
				S_REM_RD: begin
					state_q <= S_REM_WR;
				end
				S_REM_WR: begin
					if (CNTW'(idx_q) + CNTW'(1) >= cnt_q) begin
						cnt_q   <= cnt_q - CNTW'(1);
						state_q <= rm_next;
					end else begin
						idx_q   <= idx_q + QIW'(1);
						state_q <= S_REM_RD;
					end
				end
				S_INS_BEGIN: begin
					if (cnt_q == '0) begin
						state_q <= S_INS_W0;
					end else begin
						idx_q   <= QIW'(cnt_q - CNTW'(1));
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CK;
				end
				S_INS_CK: begin
					if (ram_rdata.due <= tick_q) begin
						cnt_q   <= cnt_q + CNTW'(1);
						state_q <= S_RESP;
					end else if (idx_q == '0) begin
						state_q <= S_INS_W0;
					end else begin
						idx_q   <= idx_q - QIW'(1);
						state_q <= S_INS_RD;
					end
				end
				S_INS_W0: begin
					cnt_q   <= cnt_q + CNTW'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q  <= res_status_q;
			rsp_new_id_q  <= res_new_id_q;
			rsp_queued_q  <= res_queued_q;
			rsp_etick_q   <= res_etick_q;
			rsp_clamped_q <= res_clamped_q;
		end
	end

endmodule

FILE: hdl/tesq_ram.sv
// ----------------------------------------------------------------------------
// tesq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tesq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/tesq_chk.sv
// ----------------------------------------------------------------------------
// tesq_chk
// Port-level checks on the result channel of the scheduler queue.
// ----------------------------------------------------------------------------
module tesq_chk import tesq_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input logic [STW-1:0] status,
	input logic [IDW-1:0] new_id,
	input logic           was_queued,
	input logic [TW-1:0]  entry_tick
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(new_id)
			&& $stable(entry_tick))
		else $error("result changed while stalled");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> new_id == '0 && !was_queued && entry_tick == '0)
		else $error("error result carries data");

	a_tick_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !was_queued |-> entry_tick == '0)
		else $error("entry tick without entry");

endmodule

bind timed_event_scheduler_queue_top tesq_chk u_tesq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.new_id     (rsp.new_id),
	.was_queued (rsp.was_queued),
	.entry_tick (rsp.entry_tick)
);
